// ===== sv/nfmt_pkg.sv =====
// Package for the memory-trace activation field: payload structs, register
// indexes, opcodes, reset values and pipeline constants.
// Depends on nothing; the front end, back end, top level and checker import it.
`default_nettype none
package nfmt_pkg;

  localparam int IDX_W          = 12;
  localparam int ACT_W          = 24;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_W          = 24;
  localparam int FIELD_SIZE_DEF = 4096;
  localparam int QUEUE_DEPTH    = 4;
  localparam int DIV_STAGES     = 16;
  localparam int PIPE_STAGES    = 3 + DIV_STAGES + 6;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUILD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEEP = 3'd4;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [2:0] MODE_GATED  = 3'd0;
  localparam logic [2:0] MODE_THRESH = 3'd1;
  localparam logic [2:0] MODE_INPUT  = 3'd2;

  localparam logic [2:0]         RST_MODE  = 3'd0;
  localparam logic [15:0]        RST_BUILD = 16'd655;
  localparam logic [15:0]        RST_DECAY = 16'd66;
  localparam logic signed [23:0] RST_THR   = 24'sd32768;
  localparam logic [15:0]        RST_STEEP = 16'd1000;

  localparam logic [16:0]        HALF_Q16   = 17'd32768;
  localparam logic [16:0]        ONE_Q16    = 17'd65536;
  localparam logic signed [23:0] PEAK_GATE  = 24'sd6553;

  typedef struct packed {
    logic                    opcode;
    logic [IDX_W-1:0]        element_index;
    logic signed [ACT_W-1:0] input_value;
    logic signed [ACT_W-1:0] peak_value;
  } nfmt_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        result_index;
    logic signed [ACT_W-1:0] new_activation;
  } nfmt_out_t;

  typedef struct packed {
    logic [2:0]              update_mode;
    logic [15:0]             build_rate;
    logic [15:0]             decay_rate;
    logic signed [ACT_W-1:0] sigmoid_threshold;
    logic [15:0]             sigmoid_steepness;
  } nfmt_cfg_t;

  typedef struct packed {
    logic     valid;
    nfmt_in_t item;
  } nfmt_head_t;

  typedef struct packed {
    logic pop;
    logic sweep_busy;
  } nfmt_ctl_t;

endpackage
`default_nettype wire

// ===== sv/nfmt_ram.sv =====
// Generic single-write, single-read RAM with a registered, enabled read port.
// Depends on nothing.
`default_nettype none
module nfmt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== sv/nfmt_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side
// payload that travels alongside. Depends on nothing.
`default_nettype none
module nfmt_div #(
  parameter int NW = 57,
  parameter int DW = 42,
  parameter int QW = 16,
  parameter int SW = 73
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side_in,
  output logic      [QW-1:0] quo,
  output logic      [SW-1:0] side_out
);

  logic [NW-1:0] rem_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [SW-1:0] side_r [QW];

  logic [NW-1:0] rem_in  [QW];
  logic [DW-1:0] den_in  [QW];
  logic [QW-1:0] quo_in  [QW];
  logic [SW-1:0] side_a  [QW];

  assign rem_in[0] = num;
  assign den_in[0] = den;
  assign quo_in[0] = '0;
  assign side_a[0] = side_in;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int J = QW - 1 - k;
    logic [NW-1:0] dsh;
    logic          take;

    if (k > 0) begin : g_link
      assign rem_in[k] = rem_r[k-1];
      assign den_in[k] = den_r[k-1];
      assign quo_in[k] = quo_r[k-1];
      assign side_a[k] = side_r[k-1];
    end

    assign dsh  = NW'(den_in[k]) << J;
    assign take = (rem_in[k] >= dsh);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? (rem_in[k] - dsh) : rem_in[k];
        den_r[k]  <= den_in[k];
        quo_r[k]  <= quo_in[k] | (take ? (QW'(1) << J) : '0);
        side_r[k] <= side_a[k];
      end
    end
  end

  assign quo      = quo_r[QW-1];
  assign side_out = side_r[QW-1];

endmodule
`default_nettype wire

// ===== sv/nfmt_front.sv =====
// Front end: accepts transactions, drops updates outside the field and
// queues the rest for the back end. Depends on nfmt_pkg.
`default_nettype none
module nfmt_front
  import nfmt_pkg::*;
#(
  parameter int FIELD_SIZE = FIELD_SIZE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire nfmt_in_t   in_data,
  input  wire nfmt_ctl_t  ctl,
  output nfmt_head_t      head
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  nfmt_in_t      q_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          keep, push, pop;

  assign keep = (in_data.opcode == OP_CLEAR) ||
                ({5'd0, in_data.element_index} < 17'(FIELD_SIZE));
  assign in_stall = (cnt_r == CW'(QUEUE_DEPTH)) || ctl.sweep_busy;
  assign push     = in_valid && !in_stall && keep;
  assign pop      = ctl.pop && (cnt_r != '0);

  always_comb begin
    wp_nxt  = push ? wp_r + PW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + PW'(1) : rp_r;
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= in_data;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_r[rp_r];

endmodule
`default_nettype wire

// ===== sv/nfmt_back.sv =====
// Back end: reads the stored activation, runs the sigmoid division and the
// Euler update, writes back and holds the result register; also clears the
// store. Depends on nfmt_pkg, nfmt_ram and nfmt_div.
`default_nettype none
module nfmt_back
  import nfmt_pkg::*;
#(
  parameter int FIELD_SIZE = FIELD_SIZE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire nfmt_cfg_t  cfg,
  input  wire nfmt_head_t head,
  output nfmt_ctl_t       ctl,
  output logic            out_valid,
  input  wire logic       out_stall,
  output nfmt_out_t       out_data
);

  localparam int AW = (FIELD_SIZE > 1) ? $clog2(FIELD_SIZE) : 1;
  localparam int NS = PIPE_STAGES;
  localparam int NW = 57;
  localparam int DW = 42;
  localparam int SW = 1 + 3 * ACT_W;
  localparam logic signed [60:0] RND32 = 61'sd2147483648;
  localparam logic signed [52:0] RND16 = 53'sd32768;

  logic          adv, hazard, pipe_empty, issue, start_clr;
  logic [AW-1:0] hidx;
  logic          vl_r [NS];
  logic [AW-1:0] idx_r [NS];
  logic          sweep_r, sweep_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [ACT_W-1:0]        ram_wdata, ram_rdata;

  logic signed [ACT_W-1:0] x1_r, p1_r, x2_r, p2_r, a2_r;
  logic                    neg1_r, neg2_r;
  logic signed [24:0]      dif;
  logic [24:0]             mag1_r;
  logic [40:0]             bm2_r;
  logic [NW-1:0]           num3_r;
  logic [DW-1:0]           den3_r;
  logic [SW-1:0]           side3_r, side_d;
  logic [DIV_STAGES-1:0]   quo_d;

  logic                    neg_d;
  logic signed [ACT_W-1:0] xd, pd, ad;
  logic [16:0]             s_c;
  logic [16:0]             se_r, omse_r;
  logic signed [24:0]      xae_r;
  logic signed [ACT_W-1:0] xe_r, pe_r, ae_r;

  logic signed [42:0]      pbf_r, pdf_r;
  logic signed [ACT_W-1:0] xf_r, pf_r, af_r;

  logic signed [60:0]      bg_r, dg_r;
  logic signed [ACT_W-1:0] xg_r, pg_r, ag_r;

  logic                    mode_in;
  logic signed [60:0]      sum1, sum2;
  logic signed [28:0]      t1h_r, t2h_r;
  logic                    gateh_r;
  logic signed [ACT_W-1:0] xh_r, ph_r, ah_r;

  logic signed [52:0]      m1i_r, m2i_r;
  logic                    gatei_r;
  logic signed [ACT_W-1:0] ai_r;

  logic signed [52:0]      r1, r2;
  logic signed [37:0]      d1, d2, delta_c, deltaj_r;
  logic signed [ACT_W-1:0] aj_r;

  logic signed [38:0]      na_w;
  logic signed [ACT_W-1:0] na_c;
  logic                    out_valid_r;
  nfmt_out_t               out_data_r;

  assign adv        = !out_valid_r || !out_stall;
  assign hidx       = AW'(head.item.element_index);
  assign mode_in    = (cfg.update_mode >= MODE_INPUT);

  always_comb begin
    hazard     = 1'b0;
    pipe_empty = 1'b1;
    for (int i = 0; i < NS; i++) begin
      if (vl_r[i]) begin
        pipe_empty = 1'b0;
        if (idx_r[i] == hidx) begin
          hazard = 1'b1;
        end
      end
    end
  end

  assign issue     = head.valid && (head.item.opcode == OP_UPDATE) && !hazard &&
                     adv && !sweep_r;
  assign start_clr = head.valid && (head.item.opcode == OP_CLEAR) && pipe_empty &&
                     !sweep_r;
  assign ctl.pop        = issue || start_clr;
  assign ctl.sweep_busy = sweep_r;

  always_comb begin
    sweep_nxt = sweep_r;
    cnt_nxt   = cnt_r;
    if (sweep_r) begin
      cnt_nxt = cnt_r + AW'(1);
      if (cnt_r == AW'(FIELD_SIZE - 1)) begin
        sweep_nxt = 1'b0;
        cnt_nxt   = '0;
      end
    end else if (start_clr) begin
      sweep_nxt = 1'b1;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= 1'b1;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        vl_r[i] <= 1'b0;
      end
    end else begin
      sweep_r <= sweep_nxt;
      cnt_r   <= cnt_nxt;
      if (adv) begin
        out_valid_r <= vl_r[NS-1];
        vl_r[0]     <= issue;
        for (int i = 1; i < NS; i++) begin
          vl_r[i] <= vl_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_r[0] <= hidx;
      for (int i = 1; i < NS; i++) begin
        idx_r[i] <= idx_r[i-1];
      end
    end
  end

  assign ram_we    = sweep_r || (adv && vl_r[NS-1]);
  assign ram_waddr = sweep_r ? cnt_r : idx_r[NS-1];
  assign ram_wdata = sweep_r ? '0 : na_c;

  nfmt_ram #(
    .WIDTH (ACT_W),
    .DEPTH (FIELD_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (adv),
    .raddr (hidx),
    .rdata (ram_rdata)
  );

  assign dif = 25'(head.item.input_value) - 25'(cfg.sigmoid_threshold);

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r   <= head.item.input_value;
      p1_r   <= head.item.peak_value;
      neg1_r <= dif[24];
      mag1_r <= dif[24] ? 25'(-dif) : 25'(dif);

      x2_r   <= x1_r;
      p2_r   <= p1_r;
      neg2_r <= neg1_r;
      a2_r   <= $signed(ram_rdata);
      bm2_r  <= 41'(cfg.sigmoid_steepness) * 41'(mag1_r);

      num3_r  <= (NW'(bm2_r) << 15) + NW'(HALF_Q16) + NW'(bm2_r >> 1);
      den3_r  <= DW'(bm2_r) + DW'(ONE_Q16);
      side3_r <= {neg2_r, x2_r, p2_r, a2_r};
    end
  end

  nfmt_div #(
    .NW (NW),
    .DW (DW),
    .QW (DIV_STAGES),
    .SW (SW)
  ) u_div (
    .clk      (clk),
    .en       (adv),
    .num      (num3_r),
    .den      (den3_r),
    .side_in  (side3_r),
    .quo      (quo_d),
    .side_out (side_d)
  );

  assign neg_d = side_d[SW-1];
  assign xd    = $signed(side_d[3*ACT_W-1:2*ACT_W]);
  assign pd    = $signed(side_d[2*ACT_W-1:ACT_W]);
  assign ad    = $signed(side_d[ACT_W-1:0]);
  assign s_c   = neg_d ? (HALF_Q16 - 17'(quo_d)) : (HALF_Q16 + 17'(quo_d));

  assign sum1 = (mode_in ? bg_r : (bg_r - dg_r)) + RND32;
  assign sum2 = dg_r + RND32;
  assign r1   = m1i_r + RND16;
  assign r2   = m2i_r + RND16;
  assign d1   = 38'(r1 >>> 16);
  assign d2   = 38'(r2 >>> 16);

  always_comb begin
    if (mode_in) begin
      delta_c = d1 - d2;
    end else if ((cfg.update_mode == MODE_THRESH) && !gatei_r) begin
      delta_c = '0;
    end else begin
      delta_c = d1;
    end
  end

  assign na_w = 39'(aj_r) + 39'(deltaj_r);
  always_comb begin
    if (na_w > 39'sd8388607) begin
      na_c = 24'sd8388607;
    end else if (na_w < -39'sd8388608) begin
      na_c = -24'sd8388608;
    end else begin
      na_c = na_w[ACT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      se_r   <= s_c;
      omse_r <= ONE_Q16 - s_c;
      xae_r  <= 25'(xd) - 25'(ad);
      xe_r   <= xd;
      pe_r   <= pd;
      ae_r   <= ad;

      pbf_r <= 43'(xae_r) * $signed({26'd0, se_r});
      pdf_r <= 43'(ae_r) * $signed({26'd0,
               (cfg.update_mode == MODE_GATED) ? se_r : omse_r});
      xf_r  <= xe_r;
      pf_r  <= pe_r;
      af_r  <= ae_r;

      bg_r <= 61'(pbf_r) * $signed({45'd0, cfg.build_rate});
      dg_r <= 61'(pdf_r) * $signed({45'd0, cfg.decay_rate});
      xg_r <= xf_r;
      pg_r <= pf_r;
      ag_r <= af_r;

      t1h_r   <= sum1[60:32];
      t2h_r   <= sum2[60:32];
      gateh_r <= (pg_r > PEAK_GATE);
      xh_r    <= xg_r;
      ph_r    <= pg_r;
      ah_r    <= ag_r;

      m1i_r   <= 53'(t1h_r) * 53'(mode_in ? xh_r : ph_r);
      m2i_r   <= 53'(t2h_r) * 53'(ph_r);
      gatei_r <= gateh_r;
      ai_r    <= ah_r;

      deltaj_r <= delta_c;
      aj_r     <= ai_r;

      out_data_r.result_index   <= IDX_W'(idx_r[NS-1]);
      out_data_r.new_activation <= na_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== sv/neural_field_memory_trace.sv =====
// Top level of the memory-trace activation field: configuration registers,
// front-end queue and back-end update pipeline. Depends on nfmt_pkg,
// nfmt_front and nfmt_back.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_stall   nfmt_in_t
//   out_     output     out_valid/out_stall nfmt_out_t
//   cfg_     input      cfg_we              cfg_index, cfg_wdata
//
// One update is taken per cycle unless an output stall, a hazard or a sweep
// holds it; its result passes the 16-stage sigmoid divider plus the read,
// multiply and rounding stages. An update to an index still in flight waits
// until that element is written. After reset and after each clear transaction
// a sweep zeroes the store at one element per cycle while in_stall is held
// high. A stalled output holds the pipeline; the queue accepts until full.
`default_nettype none
module neural_field_memory_trace
  import nfmt_pkg::*;
#(
  parameter int FIELD_SIZE = FIELD_SIZE_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire nfmt_in_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output nfmt_out_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  nfmt_cfg_t  cfg_r;
  nfmt_head_t head;
  nfmt_ctl_t  ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.update_mode       <= RST_MODE;
      cfg_r.build_rate        <= RST_BUILD;
      cfg_r.decay_rate        <= RST_DECAY;
      cfg_r.sigmoid_threshold <= RST_THR;
      cfg_r.sigmoid_steepness <= RST_STEEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:  cfg_r.update_mode       <= cfg_wdata[2:0];
        REG_BUILD: cfg_r.build_rate        <= cfg_wdata[15:0];
        REG_DECAY: cfg_r.decay_rate        <= cfg_wdata[15:0];
        REG_THR:   cfg_r.sigmoid_threshold <= $signed(cfg_wdata);
        REG_STEEP: cfg_r.sigmoid_steepness <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  nfmt_front #(
    .FIELD_SIZE (FIELD_SIZE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .ctl      (ctl),
    .head     (head)
  );

  nfmt_back #(
    .FIELD_SIZE (FIELD_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .ctl       (ctl),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== sv/nfmt_chk.sv =====
// Port-level checker for the memory-trace field, bound to the top level.
// Depends on nfmt_pkg.
`default_nettype none
module nfmt_chk
  import nfmt_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire nfmt_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("Stalled result transaction was dropped.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("Stalled result transaction changed.");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_rst_sweep: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("Input accepted while the store is being cleared.");

endmodule

bind neural_field_memory_trace nfmt_chk u_nfmt_chk (.*);
`default_nettype wire
